// ===== rtl/nlv_pkg.sv =====
// ============================================================================
// nlv_pkg: shared types and constants of the numeric literal validator
// Character codes, radix and status codes, parse phases and scanner state.
// ============================================================================
`default_nettype none

package nlv_pkg;

    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int RADIX_W  = 2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_SEP   = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_LP    = 8'h70;
    localparam logic [CHAR_W-1:0] CH_UP    = 8'h50;
    localparam logic [CHAR_W-1:0] CH_LE    = 8'h65;
    localparam logic [CHAR_W-1:0] CH_UE    = 8'h45;
    localparam logic [CHAR_W-1:0] CH_LI    = 8'h69;
    localparam logic [CHAR_W-1:0] CH_LU    = 8'h75;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5f;

    // radix codes
    localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd0;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd1;
    localparam logic [RADIX_W-1:0] RADIX_BIN = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERSCORE = 2'd2;

    typedef enum logic [6:0] {
        PH_START   = 7'b000_0001,
        PH_ZERO    = 7'b000_0010,
        PH_INT     = 7'b000_0100,
        PH_FRAC    = 7'b000_1000,
        PH_EXPSIGN = 7'b001_0000,
        PH_EXP     = 7'b010_0000,
        PH_SUF     = 7'b100_0000
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [RADIX_W-1:0] radix;
        logic               run_has_digit;
        logic               prev_was_sep;
        logic               saw_underscore;
        logic               failed;
    } t_lit_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RADIX_W-1:0]  radix_code;
    } t_lit_result;

    localparam t_lit_state LIT_CLEAR = '{
        phase:          PH_START,
        radix:          RADIX_DEC,
        run_has_digit:  1'b0,
        prev_was_sep:   1'b0,
        saw_underscore: 1'b0,
        failed:         1'b0
    };

endpackage

`default_nettype wire

// ===== rtl/nlv_if.sv =====
// ============================================================================
// nlv_if: item channels of the numeric literal validator
// Valid/ready channels for literal characters in and verdicts out.
// ============================================================================
`default_nettype none

interface nlv_in_if;
    logic                       valid;
    logic                       ready;
    logic [nlv_pkg::CHAR_W-1:0] character;
    logic                       final_char;

    modport source (output valid, output character, output final_char, input ready);
    modport sink   (input valid, input character, input final_char, output ready);
endinterface

interface nlv_out_if;
    logic                         valid;
    logic                         ready;
    logic [nlv_pkg::STATUS_W-1:0] status;
    logic [nlv_pkg::RADIX_W-1:0]  radix_code;

    modport source (output valid, output status, output radix_code, input ready);
    modport sink   (input valid, input status, input radix_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/nlv_step.sv =====
// ============================================================================
// nlv_step: one-character transition of the literal scanner
// Next scanner state from the current state and one character, plus the
// verdict that a literal ending on this character gets.
// ============================================================================
`default_nettype none

module nlv_step (
    input  nlv_pkg::t_lit_state          i_state,
    input  logic [nlv_pkg::CHAR_W-1:0]   i_character,
    output nlv_pkg::t_lit_state          o_state,
    output nlv_pkg::t_lit_result         o_result
);

    function automatic logic digit_of(input logic [nlv_pkg::CHAR_W-1:0] c,
                                      input logic [nlv_pkg::RADIX_W-1:0] rad);
        logic dec;
        dec = (c >= nlv_pkg::CH_0) && (c <= nlv_pkg::CH_9);
        case (rad)
            nlv_pkg::RADIX_HEX:
                return dec || ((c >= nlv_pkg::CH_LA) && (c <= nlv_pkg::CH_LF))
                           || ((c >= nlv_pkg::CH_UA) && (c <= nlv_pkg::CH_UF));
            nlv_pkg::RADIX_BIN: return (c == nlv_pkg::CH_0) || (c == nlv_pkg::CH_1);
            default:            return dec;
        endcase
    endfunction

    logic [nlv_pkg::CHAR_W-1:0]  c;
    logic [nlv_pkg::RADIX_W-1:0] run_rad;
    logic                        take_dig;
    logic                        take_sep;
    logic                        clean;
    logic                        is_suffix;
    logic                        is_exp;
    logic                        ends_well;
    nlv_pkg::t_lit_state         n_st;

    assign c        = i_character;
    assign run_rad  = (i_state.phase == nlv_pkg::PH_INT || i_state.phase == nlv_pkg::PH_FRAC)
                      ? i_state.radix : nlv_pkg::RADIX_DEC;
    assign take_dig = digit_of(c, run_rad);
    assign take_sep = (c == nlv_pkg::CH_SEP) && i_state.run_has_digit && !i_state.prev_was_sep;
    assign clean    = i_state.run_has_digit && !i_state.prev_was_sep;
    assign is_suffix = (c == nlv_pkg::CH_LI) || (c == nlv_pkg::CH_LU) || (c == nlv_pkg::CH_LF);
    assign is_exp   = (c == nlv_pkg::CH_LP) || (c == nlv_pkg::CH_UP)
                      || ((i_state.radix == nlv_pkg::RADIX_DEC)
                          && ((c == nlv_pkg::CH_LE) || (c == nlv_pkg::CH_UE)));

    always_comb begin
        n_st = i_state;
        if (c == nlv_pkg::CH_UNDER) begin
            n_st.saw_underscore = 1'b1;
        end
        if (!i_state.failed) begin
            unique case (i_state.phase) inside
                nlv_pkg::PH_START: begin
                    // leading zero may open a prefix; any other start is a fresh run
                    n_st.prev_was_sep = 1'b0;
                    if (c == nlv_pkg::CH_0) begin
                        n_st.phase         = nlv_pkg::PH_ZERO;
                        n_st.run_has_digit = 1'b1;
                    end else begin
                        n_st.phase         = nlv_pkg::PH_INT;
                        n_st.run_has_digit = digit_of(c, nlv_pkg::RADIX_DEC);
                        n_st.failed        = !digit_of(c, nlv_pkg::RADIX_DEC);
                    end
                end
                nlv_pkg::PH_ZERO, nlv_pkg::PH_INT: begin
                    n_st.phase = nlv_pkg::PH_INT;
                    if ((i_state.phase == nlv_pkg::PH_ZERO)
                        && (c == nlv_pkg::CH_LX || c == nlv_pkg::CH_UX)) begin
                        n_st.radix         = nlv_pkg::RADIX_HEX;
                        n_st.run_has_digit = 1'b0;
                        n_st.prev_was_sep  = 1'b0;
                    end else if ((i_state.phase == nlv_pkg::PH_ZERO)
                        && (c == nlv_pkg::CH_LB || c == nlv_pkg::CH_UB)) begin
                        n_st.radix         = nlv_pkg::RADIX_BIN;
                        n_st.run_has_digit = 1'b0;
                        n_st.prev_was_sep  = 1'b0;
                    end else if (take_dig) begin
                        n_st.run_has_digit = 1'b1;
                        n_st.prev_was_sep  = 1'b0;
                    end else if (take_sep) begin
                        n_st.prev_was_sep = 1'b1;
                    end else if (!clean) begin
                        n_st.failed = 1'b1;
                    end else begin
                        n_st.run_has_digit = 1'b0;
                        n_st.prev_was_sep  = 1'b0;
                        if (c == nlv_pkg::CH_DOT) begin
                            n_st.phase = nlv_pkg::PH_FRAC;
                        end else if (is_exp) begin
                            n_st.phase = nlv_pkg::PH_EXPSIGN;
                        end else if (is_suffix) begin
                            n_st.phase = nlv_pkg::PH_SUF;
                        end else begin
                            n_st = i_state;
                            n_st.saw_underscore = i_state.saw_underscore
                                                  || (c == nlv_pkg::CH_UNDER);
                            n_st.failed = 1'b1;
                        end
                    end
                end
                nlv_pkg::PH_FRAC: begin
                    if (take_dig) begin
                        n_st.run_has_digit = 1'b1;
                        n_st.prev_was_sep  = 1'b0;
                    end else if (take_sep) begin
                        n_st.prev_was_sep = 1'b1;
                    end else if (i_state.run_has_digit && i_state.prev_was_sep) begin
                        n_st.failed = 1'b1;
                    end else if (is_exp) begin
                        n_st.phase         = nlv_pkg::PH_EXPSIGN;
                        n_st.run_has_digit = 1'b0;
                        n_st.prev_was_sep  = 1'b0;
                    end else if (is_suffix) begin
                        n_st.phase         = nlv_pkg::PH_SUF;
                        n_st.run_has_digit = 1'b0;
                        n_st.prev_was_sep  = 1'b0;
                    end else begin
                        n_st.failed = 1'b1;
                    end
                end
                nlv_pkg::PH_EXPSIGN: begin
                    // a sign opens the exponent run, else the char must be its digit
                    n_st.phase        = nlv_pkg::PH_EXP;
                    n_st.prev_was_sep = 1'b0;
                    if (c == nlv_pkg::CH_PLUS || c == nlv_pkg::CH_MINUS) begin
                        n_st.run_has_digit = 1'b0;
                    end else begin
                        n_st.run_has_digit = take_dig;
                        n_st.failed        = !take_dig;
                    end
                end
                nlv_pkg::PH_EXP: begin
                    if (take_dig) begin
                        n_st.run_has_digit = 1'b1;
                        n_st.prev_was_sep  = 1'b0;
                    end else if (take_sep) begin
                        n_st.prev_was_sep = 1'b1;
                    end else if (clean && is_suffix) begin
                        n_st.phase         = nlv_pkg::PH_SUF;
                        n_st.run_has_digit = 1'b0;
                        n_st.prev_was_sep  = 1'b0;
                    end else begin
                        n_st.failed = 1'b1;
                    end
                end
                nlv_pkg::PH_SUF: begin
                    if (take_dig) begin
                        n_st.run_has_digit = 1'b1;
                        n_st.prev_was_sep  = 1'b0;
                    end else if (take_sep) begin
                        n_st.prev_was_sep = 1'b1;
                    end else begin
                        n_st.failed = 1'b1;
                    end
                end
                default: begin
                    n_st.failed = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        unique case (n_st.phase) inside
            nlv_pkg::PH_ZERO:  ends_well = 1'b1;
            nlv_pkg::PH_INT, nlv_pkg::PH_EXP, nlv_pkg::PH_SUF:
                ends_well = n_st.run_has_digit && !n_st.prev_was_sep;
            nlv_pkg::PH_FRAC:  ends_well = !(n_st.run_has_digit && n_st.prev_was_sep);
            default:           ends_well = 1'b0;
        endcase
    end

    assign o_state = n_st;

    always_comb begin
        if (!n_st.failed && ends_well) begin
            o_result.status = nlv_pkg::ST_OK;
        end else if (n_st.saw_underscore) begin
            o_result.status = nlv_pkg::ST_UNDERSCORE;
        end else begin
            o_result.status = nlv_pkg::ST_MALFORMED;
        end
        o_result.radix_code = n_st.radix;
    end

endmodule

`default_nettype wire

// ===== rtl/numeric_literal_validator.sv =====
// ============================================================================
// numeric_literal_validator: streaming check of one number literal
// Scans a literal one character per item and reports status and radix on
// the item flagged as its last character.
// ============================================================================
//
//  channel   | dir | payload                         | when
//  ----------+-----+---------------------------------+--------------------------
//  i_in_ch   | in  | character[7:0], final_char      | one item per character
//  o_out_ch  | out | status[1:0], radix_code[1:0]    | one item per final_char
//
//  Throughput is one character per cycle unless a final character stalls;
//  a result passes through the input register, then the result register.
//  The scanner state updates once per character in a single pass through
//  nlv_step; a new character is taken while a result waits downstream.
//  A final character stalls in the input register only while the result
//  register is full and not being taken.
//  Reset (i_rst_n low, synchronous) empties both registers and returns
//  the scanner to the start of a literal.
// ============================================================================
`default_nettype none

module numeric_literal_validator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nlv_in_if.sink         i_in_ch,
    nlv_out_if.source      o_out_ch
);

    // input register
    logic                         r_in_vld;
    logic [nlv_pkg::CHAR_W-1:0]   r_in_char;
    logic                         r_in_final;

    // scanner state
    nlv_pkg::t_lit_state          r_state;
    nlv_pkg::t_lit_state          n_state;
    nlv_pkg::t_lit_result         n_result;

    // result register
    logic                         r_out_vld;
    nlv_pkg::t_lit_result         r_out;

    logic                         out_free;
    logic                         advance;
    logic                         in_take;

    // a non-final character never needs the result slot
    assign out_free = !r_out_vld || o_out_ch.ready;
    assign advance  = r_in_vld && (!r_in_final || out_free);
    assign in_take  = i_in_ch.valid && i_in_ch.ready;

    assign i_in_ch.ready = !r_in_vld || advance;

    nlv_step u_step (
        .i_state     (r_state),
        .i_character (r_in_char),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // hold the character until the scanner takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char  <= i_in_ch.character;
            r_in_final <= i_in_ch.final_char;
        end
    end

    // advance the scanner; a final character clears it for the next literal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nlv_pkg::LIT_CLEAR;
        end else if (advance) begin
            r_state <= r_in_final ? nlv_pkg::LIT_CLEAR : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && r_in_final) begin
            r_out_vld <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_final) begin
            r_out <= n_result;
        end
    end

    assign o_out_ch.valid      = r_out_vld;
    assign o_out_ch.status     = r_out.status;
    assign o_out_ch.radix_code = r_out.radix_code;

endmodule

`default_nettype wire

// ===== rtl/nlv_checker.sv =====
// ============================================================================
// nlv_checker: port-level checks of the numeric literal validator
// Watches the result channel and reset behavior from the top-level ports.
// ============================================================================
`default_nettype none

module nlv_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [nlv_pkg::STATUS_W-1:0] i_status,
    input logic [nlv_pkg::RADIX_W-1:0]  i_radix_code
);

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
                                        && $stable(i_radix_code))
        else $error("result changed while stalled");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == nlv_pkg::ST_OK || i_status == nlv_pkg::ST_MALFORMED
                         || i_status == nlv_pkg::ST_UNDERSCORE))
        else $error("undefined status code");

    a_radix_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_radix_code == nlv_pkg::RADIX_DEC
                         || i_radix_code == nlv_pkg::RADIX_HEX
                         || i_radix_code == nlv_pkg::RADIX_BIN))
        else $error("undefined radix code");

    // nothing is left in the result register right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind numeric_literal_validator nlv_checker u_nlv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_status     (o_out_ch.status),
    .i_radix_code (o_out_ch.radix_code)
);

`default_nettype wire
